[rtl/double_to_int_saturating_convert_defines.svh]
// assertion macros for the conversion block
`ifndef DOUBLE_TO_INT_SATURATING_CONVERT_DEFINES_SVH
`define DOUBLE_TO_INT_SATURATING_CONVERT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define D2I_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define D2I_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/d2i_pkg.sv]
// ----------------------------------------------------------------------------
// d2i_pkg
// target kind codes and pipeline stage types for the binary64 converter
// ----------------------------------------------------------------------------
`default_nettype none
package d2i_pkg;

    typedef enum logic [3:0] {
        KIND_F64 = 4'd0,
        KIND_F32 = 4'd1,
        KIND_S8  = 4'd2,
        KIND_S16 = 4'd3,
        KIND_S32 = 4'd4,
        KIND_S64 = 4'd5,
        KIND_U8  = 4'd6,
        KIND_U16 = 4'd7,
        KIND_U32 = 4'd8,
        KIND_U64 = 4'd9
    } kind_t;

    // operation class after decode
    typedef enum logic [2:0] {
        OP_PASS  = 3'd0,
        OP_FLOAT = 3'd1,
        OP_INT   = 3'd2,
        OP_ZERO  = 3'd3
    } op_t;

    // stage 1 -> stage 2: decoded fields, shift amount
    typedef struct packed {
        op_t         op;
        logic [63:0] raw;
        logic        sign;
        logic        is_nan;
        logic        big;
        logic        fixed_res;
        logic [31:0] fixed_val;
        logic [52:0] mant;
        logic        left;
        logic [6:0]  shamt;
        logic [7:0]  f_base;
        logic [6:0]  width;
        logic        is_signed;
    } st1_t;

    // stage 2 -> stage 3: shifted magnitude and rounding bits
    typedef struct packed {
        op_t         op;
        logic [63:0] raw;
        logic        sign;
        logic        is_nan;
        logic        big;
        logic        fixed_res;
        logic [31:0] fixed_val;
        logic [63:0] q;
        logic        guard;
        logic        sticky;
        logic [7:0]  f_base;
        logic [6:0]  width;
        logic        is_signed;
    } st2_t;

endpackage
`default_nettype wire

[rtl/double_to_int_saturating_convert.sv]
// ----------------------------------------------------------------------------
// double_to_int_saturating_convert
// binary64 to binary32 or saturating integer conversion, when not stalled one request a cycle
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one binary64 pattern per request; m_axis returns the
//   converted pattern, zero-extended to 64 bits, in request order.
//   cfg_* writes target_kind (0 f64, 1 f32, 2-5 s8..s64, 6-9 u8..u64);
//   write it only while the pipeline is empty.
//   m_axis_tvalid rises once the request has passed four register stages.
//   throughput: one request per cycle when not stalled; the four pipeline registers
//   (decode, shift, round, saturate) all advance together.
//   when the receiver stalls, the whole pipeline holds; s_axis_tready is
//   high while the output stage is empty or being taken.
//   reset clears all valid bits and sets target_kind to binary64.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_to_int_saturating_convert_defines.svh"
module double_to_int_saturating_convert
    import d2i_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // value_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // result_bits
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);

    logic [3:0] kind_reg;
    logic       en;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_F64;
        else if (cfg_valid)
            kind_reg <= cfg_data;
    end

    d2i_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_bits   (s_axis_tdata),
        .kind      (kind_reg),
        .out_valid (m_axis_tvalid),
        .out_bits  (m_axis_tdata)
    );

    `D2I_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `D2I_ASSERT_IMP(a_ready, !m_axis_tvalid, s_axis_tready, "not ready while empty")

endmodule
`default_nettype wire

[rtl/d2i_core.sv]
// ----------------------------------------------------------------------------
// d2i_core
// four stage conversion pipeline with a shared stall enable
// ----------------------------------------------------------------------------
`default_nettype none
module d2i_core
    import d2i_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_bits,
    input  wire logic [3:0]  kind,
    output logic             out_valid,
    output logic [63:0]      out_bits
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    st1_t        s1_reg, s1_next;
    st2_t        s2_reg, s2_next;
    logic [63:0] q3_reg, q3_next;
    st2_t        s3_reg;
    logic [63:0] res_reg, res_next;

    // stage 1: decode
    always_comb
    begin
        logic        s;
        logic [10:0] e;
        logic [51:0] f;
        logic [11:0] sh;
        s = in_bits[63];
        e = in_bits[62:52];
        f = in_bits[51:0];
        sh = 12'd0;
        s1_next = '0;
        s1_next.raw = in_bits;
        s1_next.sign = s;
        s1_next.mant = {(e != 11'd0), f};
        case (kind)
            KIND_F64: s1_next.op = OP_PASS;
            KIND_F32:
            begin
                s1_next.op = OP_FLOAT;
                if (e == 11'h7FF)
                begin
                    s1_next.fixed_res = 1'b1;
                    s1_next.fixed_val = (f == 52'd0) ? {s, 31'h7F800000}
                        : {s, 8'hFF, 1'b1, f[50:29]};
                end
                else if (e == 11'd0 || e < 11'd873)
                begin
                    s1_next.fixed_res = 1'b1;
                    s1_next.fixed_val = {s, 31'd0};
                end
                else if (e >= 11'd1151)
                begin
                    s1_next.fixed_res = 1'b1;
                    s1_next.fixed_val = {s, 31'h7F800000};
                end
                else if (e >= 11'd897)
                begin
                    s1_next.f_base = 8'(e - 11'd897);
                    s1_next.shamt = 7'd29;
                end
                else
                begin
                    s1_next.shamt = 7'(12'd926 - {1'b0, e});
                end
            end
            KIND_S8, KIND_S16, KIND_S32, KIND_S64,
            KIND_U8, KIND_U16, KIND_U32, KIND_U64:
            begin
                s1_next.op = OP_INT;
                s1_next.is_signed = (kind <= KIND_S64);
                case (kind)
                    KIND_S8, KIND_U8:   s1_next.width = 7'd8;
                    KIND_S16, KIND_U16: s1_next.width = 7'd16;
                    KIND_S32, KIND_U32: s1_next.width = 7'd32;
                    default:            s1_next.width = 7'd64;
                endcase
                if (e == 11'h7FF)
                begin
                    s1_next.is_nan = (f != 52'd0);
                    s1_next.big = 1'b1;
                end
                else if (e >= 11'd1087)
                    s1_next.big = 1'b1;
                else if (e >= 11'd1075)
                begin
                    s1_next.left = 1'b1;
                    s1_next.shamt = 7'(e - 11'd1075);
                end
                else
                begin
                    sh = 12'd1075 - {1'b0, (e == 11'd0) ? 11'd1 : e};
                    s1_next.shamt = (sh > 12'd64) ? 7'd64 : 7'(sh);
                end
            end
            default: s1_next.op = OP_ZERO;
        endcase
    end

    // stage 2: shift, with guard and sticky on a right shift
    always_comb
    begin
        logic [116:0] w;
        w = '0;
        s2_next = '0;
        s2_next.op = s1_reg.op;
        s2_next.raw = s1_reg.raw;
        s2_next.sign = s1_reg.sign;
        s2_next.is_nan = s1_reg.is_nan;
        s2_next.big = s1_reg.big;
        s2_next.fixed_res = s1_reg.fixed_res;
        s2_next.fixed_val = s1_reg.fixed_val;
        s2_next.f_base = s1_reg.f_base;
        s2_next.width = s1_reg.width;
        s2_next.is_signed = s1_reg.is_signed;
        if (s1_reg.left)
            s2_next.q = {11'd0, s1_reg.mant} << s1_reg.shamt[5:0];
        else
        begin
            w = {s1_reg.mant, 64'd0} >> s1_reg.shamt;
            s2_next.q = {11'd0, w[116:64]};
            s2_next.guard = w[63];
            s2_next.sticky = (w[62:0] != 63'd0);
        end
    end

    // stage 3: round
    always_comb
    begin
        q3_next = s2_reg.q;
        if (s2_reg.op == OP_FLOAT)
        begin
            if (s2_reg.guard && (s2_reg.sticky || s2_reg.q[0]))
                q3_next = s2_reg.q + 64'd1;
        end
        else if (s2_reg.guard)
            q3_next = s2_reg.q + 64'd1;
    end

    // stage 4: saturate and pack
    always_comb
    begin
        logic [63:0] wmask, lim, fv;
        wmask = (s3_reg.width == 7'd64) ? '1 : ((64'd1 << s3_reg.width[5:0]) - 64'd1);
        lim = 64'd1 << 6'(s3_reg.width - 7'd1);
        fv = {32'd0, s3_reg.sign, 31'd0} | ({24'd0, s3_reg.f_base, 23'd0} + q3_reg);
        res_next = 64'd0;
        case (s3_reg.op)
            OP_PASS:  res_next = s3_reg.raw;
            OP_FLOAT: res_next = s3_reg.fixed_res ? {32'd0, s3_reg.fixed_val}
                                                  : {32'd0, fv[31:0]};
            OP_INT:
            begin
                if (s3_reg.is_nan)
                    res_next = 64'd0;
                else if (!s3_reg.is_signed)
                begin
                    if (s3_reg.sign)
                        res_next = 64'd0;
                    else if (s3_reg.big || q3_reg > wmask)
                        res_next = wmask;
                    else
                        res_next = q3_reg;
                end
                else if (s3_reg.sign)
                begin
                    if (s3_reg.big || q3_reg > lim)
                        res_next = lim & wmask;
                    else
                        res_next = (64'd0 - q3_reg) & wmask;
                end
                else if (s3_reg.big || q3_reg > lim - 64'd1)
                    res_next = lim - 64'd1;
                else
                    res_next = q3_reg;
            end
            default:  res_next = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
            q3_reg <= q3_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_bits = res_reg;

endmodule
`default_nettype wire
